>>> hw/rtl/parallel_master_port_controller_macros.svh
// Assertion helpers for the parallel master port controller.
`ifndef PARALLEL_MASTER_PORT_CONTROLLER_MACROS_SVH
`define PARALLEL_MASTER_PORT_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define PMP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define PMP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PMP_ASSERT(lbl, clk, rstn, prop, msg)
`define PMP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> hw/rtl/pmp_pkg.sv
package pmp_pkg;

    localparam int ADDR_LINES = 24;     // 16..24
    localparam int ADDR_W     = 24;     // bus address field width
    localparam int DATA_W     = 32;
    localparam int WORD_W     = 16;
    localparam int FW_W       = 5;      // holds a field width up to ADDR_W

    // CON bits
    localparam int CON_CSF_LO    = 6;
    localparam int CON_ON        = 15;
    localparam int CON_LONG_ADDR = 16;
    localparam int CON_TWO_BUF   = 17;
    localparam int CON_PRIME_RD  = 23;
    // MODE bits
    localparam int MODE_WIDE     = 10;
    localparam int MODE_INCM_LO  = 11;
    localparam int MODE_IRQM_HI  = 14;
    localparam int MODE_BSY_FLAG = 15;

    localparam logic [1:0] CSF_ONE  = 2'd1;
    localparam logic [1:0] CSF_TWO  = 2'd2;
    localparam logic [1:0] INCM_UP  = 2'd1;
    localparam logic [1:0] INCM_DN  = 2'd2;

    localparam logic [FW_W-1:0] FW_NARROW = 5'd16;
    localparam logic [FW_W-1:0] FW_WIDE   = FW_W'(ADDR_LINES);

    localparam logic [WORD_W-1:0] NO_TARGET_WORD = 16'hFFFF;

    typedef enum logic [3:0] {
        REG_CON   = 4'd0,
        REG_MODE  = 4'd1,
        REG_ADDR  = 4'd2,
        REG_DOUT  = 4'd3,
        REG_DIN   = 4'd4,
        REG_AEN   = 4'd5,
        REG_STAT  = 4'd6,
        REG_WADDR = 4'd7,
        REG_RADDR = 4'd8,
        REG_RDIN  = 4'd9
    } reg_idx_t;

    typedef struct packed {
        logic              cmd;            // 1 = register write
        logic [3:0]        reg_index;
        logic [DATA_W-1:0] write_data;
        logic [WORD_W-1:0] ext_read_word;
    } item_t;

    typedef struct packed {
        logic              cycle_event;
        logic [WORD_W-1:0] bus_write_word;
        logic [ADDR_W-1:0] bus_address;
        logic              bus_is_write;
        logic              bus_cycle;
        logic [DATA_W-1:0] read_value;
    } result_t;

    // Address lines kept by ADDR/WADDR/RADDR.
    function automatic logic [ADDR_W-1:0] addr_keep();
        logic [ADDR_W-1:0] m;
        for (int i = 0; i < ADDR_W; i++) begin
            m[i] = (i < ADDR_LINES);
        end
        return m;
    endfunction

endpackage

>>> hw/rtl/pmp_regs.sv
// Register file, decode and bus-cycle logic; state moves on fire.
module pmp_regs import pmp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  logic    target_attached,
    input  item_t   item,
    output result_t result
);

    logic [DATA_W-1:0] control_reg, mode_reg, data_out_reg, data_in_reg;
    logic [DATA_W-1:0] aen_reg, stat_reg;
    logic [ADDR_W-1:0] single_addr_reg, write_addr_reg, read_addr_reg;

    logic              is_con_wr;
    logic [DATA_W-1:0] con_eff;
    logic              on, dual, wide;
    logic [1:0]        csf, incm;
    logic [FW_W-1:0]   fwidth;
    logic [ADDR_W-1:0] fmask, cyc_addr, adv_addr, am, wd_addr;
    logic              rd_cycle, wr_cycle;
    logic [1:0]        addr_sel;       // 0 single, 1 write, 2 read
    logic [WORD_W-1:0] fetched, wr_word;
    logic [DATA_W-1:0] rv;

    localparam logic [1:0] SEL_SINGLE = 2'd0;
    localparam logic [1:0] SEL_WRITE  = 2'd1;
    localparam logic [1:0] SEL_READ   = 2'd2;

    // A CON write takes effect before its own primed read.
    assign is_con_wr = item.cmd && (reg_idx_t'(item.reg_index) == REG_CON);
    assign con_eff   = is_con_wr ? (item.write_data & ~(32'd1 << CON_PRIME_RD))
                                 : control_reg;
    assign on   = con_eff[CON_ON];
    assign dual = con_eff[CON_TWO_BUF];
    assign csf  = con_eff[CON_CSF_LO +: 2];
    assign wide = mode_reg[MODE_WIDE];
    assign incm = mode_reg[MODE_INCM_LO +: 2];
    assign am   = addr_keep();
    assign wd_addr = item.write_data[ADDR_W-1:0] & am;

    always_comb begin
        fwidth = con_eff[CON_LONG_ADDR] ? FW_WIDE : FW_NARROW;
        if (csf == CSF_TWO) begin
            fwidth = fwidth - 5'd2;
        end else if (csf == CSF_ONE) begin
            fwidth = fwidth - 5'd1;
        end
        for (int i = 0; i < ADDR_W; i++) begin
            fmask[i] = (FW_W'(i) < fwidth);
        end
    end

    // Decode
    always_comb begin
        rd_cycle = 1'b0;
        wr_cycle = 1'b0;
        addr_sel = SEL_SINGLE;
        rv       = '0;
        if (!item.cmd) begin
            case (reg_idx_t'(item.reg_index))
                REG_CON:   rv = control_reg;
                REG_MODE:  rv = mode_reg & ~(32'd1 << MODE_BSY_FLAG);
                REG_ADDR:  rv = {8'd0, single_addr_reg};
                REG_DOUT:  rv = data_out_reg;
                REG_DIN: begin
                    rv       = data_in_reg;    // previous fetch
                    rd_cycle = !dual && on;
                end
                REG_AEN:   rv = aen_reg;
                REG_STAT:  rv = stat_reg;
                REG_WADDR: rv = {8'd0, write_addr_reg};
                REG_RADDR: rv = {8'd0, read_addr_reg};
                REG_RDIN: begin
                    rv       = data_in_reg;
                    rd_cycle = dual && on;
                    addr_sel = SEL_READ;
                end
                default:   rv = '0;
            endcase
        end else begin
            case (reg_idx_t'(item.reg_index))
                REG_CON: begin
                    rd_cycle = item.write_data[CON_PRIME_RD] && on;
                    addr_sel = dual ? SEL_READ : SEL_SINGLE;
                end
                REG_DOUT: begin
                    wr_cycle = dual && on;
                    addr_sel = SEL_WRITE;
                end
                REG_DIN:   wr_cycle = !dual && on;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (addr_sel)
            SEL_WRITE: cyc_addr = write_addr_reg;
            SEL_READ:  cyc_addr = read_addr_reg;
            default:   cyc_addr = single_addr_reg;
        endcase
        case (incm)
            INCM_UP: adv_addr = ((cyc_addr & ~fmask) | ((cyc_addr + 24'd1) & fmask)) & am;
            INCM_DN: adv_addr = ((cyc_addr & ~fmask) | ((cyc_addr - 24'd1) & fmask)) & am;
            default: adv_addr = cyc_addr;
        endcase
    end

    assign fetched = (target_attached ? item.ext_read_word : NO_TARGET_WORD)
                   & (wide ? 16'hFFFF : 16'h00FF);
    assign wr_word = item.write_data[WORD_W-1:0] & (wide ? 16'hFFFF : 16'h00FF);

    always_comb begin
        result.read_value     = rv;
        result.bus_cycle      = rd_cycle || wr_cycle;
        result.bus_is_write   = wr_cycle;
        result.bus_address    = (rd_cycle || wr_cycle) ? cyc_addr : '0;
        result.bus_write_word = wr_cycle ? wr_word : '0;
        result.cycle_event    = (rd_cycle || wr_cycle) && !mode_reg[MODE_IRQM_HI];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_reg     <= '0;
            mode_reg        <= '0;
            single_addr_reg <= '0;
            write_addr_reg  <= '0;
            read_addr_reg   <= '0;
            data_out_reg    <= '0;
            data_in_reg     <= '0;
            aen_reg         <= '0;
            stat_reg        <= '0;
        end else if (fire) begin
            if (item.cmd) begin
                case (reg_idx_t'(item.reg_index))
                    REG_CON:   control_reg <= con_eff;
                    REG_MODE:  mode_reg <= item.write_data & ~(32'd1 << MODE_BSY_FLAG);
                    REG_ADDR: begin
                        single_addr_reg <= wd_addr;
                        write_addr_reg  <= wd_addr;
                        read_addr_reg   <= wd_addr;
                    end
                    REG_DOUT:  data_out_reg <= item.write_data;
                    REG_DIN:   data_in_reg  <= item.write_data;
                    REG_AEN:   aen_reg  <= item.write_data;
                    REG_STAT:  stat_reg <= item.write_data;
                    REG_WADDR: write_addr_reg <= wd_addr;
                    REG_RADDR: read_addr_reg  <= wd_addr;
                    default: ;
                endcase
            end
            if (rd_cycle) begin
                data_in_reg <= {16'd0, fetched};
            end
            if (rd_cycle || wr_cycle) begin
                case (addr_sel)
                    SEL_WRITE: write_addr_reg  <= adv_addr;
                    SEL_READ:  read_addr_reg   <= adv_addr;
                    default:   single_addr_reg <= adv_addr;
                endcase
            end
        end
    end

endmodule

>>> hw/rtl/parallel_master_port_controller.sv
// Path: each accepted item passes through the input reg, then the result reg;
// decode sits combinationally between the two.
// Throughput: 1 item per cycle while m_tready holds; register decode is combinational.
// Stalls on m_tready back up through the result reg to s_tready.
// Reset (aresetn low, synchronous): all port registers clear to zero,
// target_attached returns to 1, both pipeline regs empty.
`include "parallel_master_port_controller_macros.svh"

module parallel_master_port_controller import pmp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    // register access items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // write_data[31:0], ext_read_word[47:32]
    input  logic [4:0]  s_tuser,   // cmd[0], reg_index[4:1]

    // access results
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_value[31:0], bus_cycle[32], bus_is_write[33], bus_address[57:34],
    // bus_write_word[73:58], cycle_event[74], zero pad [79:75]
    output logic [79:0] m_tdata,

    // target_attached register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    item_t   in_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    logic    target_reg;
    logic    fire;      // held item goes through decode this cycle
    result_t result;

    // Item advances when the result reg is empty or being drained.
    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            target_reg    <= 1'b1;
        end else begin
            if (cfg_valid) begin
                target_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload regs: no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.cmd           <= s_tuser[0];
            in_reg.reg_index     <= s_tuser[4:1];
            in_reg.write_data    <= s_tdata[31:0];
            in_reg.ext_read_word <= s_tdata[47:32];
        end
        if (fire) begin
            out_reg <= result;
        end
    end

    pmp_regs u_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .fire            (fire),
        .target_attached (target_reg),
        .item            (in_reg),
        .result          (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg};

    // Every decoded item shows up as a result next cycle.
    `PMP_ASSERT(a_fire_to_out, aclk, aresetn, fire |=> m_tvalid, "decoded item lost")
    // Input reg never overwritten while it still holds an item.
    `PMP_ASSERT(a_no_overwrite, aclk, aresetn,
        (in_valid_reg && !fire) |-> !s_tready, "input reg overwritten")
    // Write flag, data, address and event only ride on a bus cycle.
    `PMP_ASSERT(a_cycle_fields, aclk, aresetn,
        (fire && !result.bus_cycle) |->
        (!result.bus_is_write && result.bus_address == '0 && !result.cycle_event),
        "bus fields without a cycle")
    `PMP_ASSERT(a_wr_word, aclk, aresetn,
        (fire && !result.bus_is_write) |-> (result.bus_write_word == '0),
        "write word without write cycle")
    // A bus cycle only comes from a data register access or a CON write.
    `PMP_ASSERT(a_cycle_src, aclk, aresetn,
        (fire && result.bus_cycle) |->
        (in_reg.reg_index == REG_DIN || in_reg.reg_index == REG_RDIN ||
         in_reg.reg_index == REG_DOUT || in_reg.reg_index == REG_CON),
        "bus cycle from wrong register")

endmodule
